// ===== rtl/wsam_pkg.sv =====
// Shared constants, codes, state type and helpers for the stripe address mapper.
`timescale 1ns / 1ps
package wsam_pkg;

  localparam int MAX_SEGMENTS = 8;
  localparam int MAX_DISKS    = 8;
  localparam int CHUNK_SIZE   = 4096;

  localparam int DW      = 64;
  localparam int CNT_W   = $clog2(DW + 1);
  localparam int SEG_AW  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int SEG_CW  = $clog2(MAX_SEGMENTS + 1);
  localparam int DISK_AW = (MAX_DISKS > 1) ? $clog2(MAX_DISKS) : 1;
  localparam int DISK_CW = $clog2(MAX_DISKS + 1);
  localparam int DK_DEPTH = MAX_SEGMENTS * MAX_DISKS;
  localparam int DK_AW   = (DK_DEPTH > 1) ? $clog2(DK_DEPTH) : 1;

  typedef enum logic [1:0] {
    FN_LOAD_SEG  = 2'd0,
    FN_LOAD_DISK = 2'd1,
    FN_FWD       = 2'd2,
    FN_REV       = 2'd3
  } func_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_F_SEG,
    ST_F_CHK,
    ST_F_DIV,
    ST_F_DRD,
    ST_F_DCHK,
    ST_F_PRD,
    ST_F_PCHK,
    ST_F_MUL,
    ST_R_SEG,
    ST_R_HDR,
    ST_R_DRD,
    ST_R_DCHK,
    ST_R_DIV,
    ST_R_SUM,
    ST_R_MUL,
    ST_R_CHK,
    ST_DONE
  } state_t;

  // weight times chunk size; fits easily in 32 bits for the allowed range
  function automatic logic [DW-1:0] slot_bytes(input logic [7:0] w);
    logic [31:0] p;
    p = 32'(int'(w) * CHUNK_SIZE);
    return DW'(p);
  endfunction

endpackage

// ===== rtl/wsam_in_if.sv =====
// Input channel: valid/ready handshake with the request item fields.
`timescale 1ns / 1ps
interface wsam_in_if;
  import wsam_pkg::*;
  logic          valid;
  logic          ready;
  logic [1:0]    func;
  logic [2:0]    seg_slot;
  logic [2:0]    disk_slot;
  logic [DW-1:0] addr;
  logic [DW-1:0] end_addr;
  logic [DW-1:0] stripe_bytes;
  logic [3:0]    disk_total;
  logic [7:0]    weight;
  logic [7:0]    disk_id;

  modport source (output valid, func, seg_slot, disk_slot, addr, end_addr, stripe_bytes,
                  disk_total, weight, disk_id, input ready);
  modport sink   (input valid, func, seg_slot, disk_slot, addr, end_addr, stripe_bytes,
                  disk_total, weight, disk_id, output ready);
endinterface

// ===== rtl/wsam_out_if.sv =====
// Result channel: valid/ready handshake with the mapping result fields.
`timescale 1ns / 1ps
interface wsam_out_if;
  import wsam_pkg::*;
  logic          valid;
  logic          ready;
  logic          status;
  logic [7:0]    disk_out;
  logic [DW-1:0] disk_offset_out;
  logic [DW-1:0] chunk_length;
  logic [DW-1:0] logical_out;

  modport source (output valid, status, disk_out, disk_offset_out, chunk_length,
                  logical_out, input ready);
  modport sink   (input valid, status, disk_out, disk_offset_out, chunk_length,
                  logical_out, output ready);
endinterface

// ===== rtl/wsam_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module wsam_div (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [wsam_pkg::DW-1:0] dividend,
  input  logic [wsam_pkg::DW-1:0] divisor,
  output logic                   done,
  output logic [wsam_pkg::DW-1:0] quot,
  output logic [wsam_pkg::DW-1:0] rem
);
  import wsam_pkg::*;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0]    q_r, q_nxt;
  logic [DW-1:0]    r_r, r_nxt;
  logic [DW-1:0]    d_r, d_nxt;
  logic [DW:0]      shifted;
  logic [DW:0]      diff;

  always_comb begin
    shifted  = {r_r, q_r[DW-1]};
    diff     = shifted - {1'b0, d_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    r_nxt    = r_r;
    d_nxt    = d_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DW);
      q_nxt    = dividend;
      r_nxt    = '0;
      d_nxt    = divisor;
    end else if (busy_r) begin
      // no borrow: subtract fits, quotient bit is one
      if (!diff[DW]) begin
        r_nxt = diff[DW-1:0];
      end else begin
        r_nxt = shifted[DW-1:0];
      end
      q_nxt   = {q_r[DW-2:0], ~diff[DW]};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    r_r <= r_nxt;
    d_r <= d_nxt;
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = r_r;
endmodule

// ===== rtl/wsam_mul.sv =====
// Bit-serial shift-add multiplier, low 64 bits of the product, one bit per cycle.
`timescale 1ns / 1ps
module wsam_mul (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [wsam_pkg::DW-1:0] op_a,
  input  logic [wsam_pkg::DW-1:0] op_b,
  output logic                   done,
  output logic [wsam_pkg::DW-1:0] prod
);
  import wsam_pkg::*;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0]    a_r, a_nxt;
  logic [DW-1:0]    b_r, b_nxt;
  logic [DW-1:0]    acc_r, acc_nxt;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DW);
      a_nxt    = op_a;
      b_nxt    = op_b;
      acc_nxt  = '0;
    end else if (busy_r) begin
      if (a_r[0]) begin
        acc_nxt = acc_r + b_r;
      end
      a_nxt   = {1'b0, a_r[DW-1:1]};
      b_nxt   = {b_r[DW-2:0], 1'b0};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;
endmodule

// ===== rtl/weighted_stripe_address_mapper.sv =====
// Top level: segment/disk tables, scan sequencer, shared serial divider and multiplier.
// Sequence: a load item is written into its table when accepted. A forward item scans
//   segments, runs the divider, scans the disk slots, then runs the multiplier.
//   A reverse item scans segments and disk slots, and runs a divide and a multiply
//   for each segment whose disk matches.
// Throughput: one item at a time; a new item is accepted only once the result has moved to the output register.
// Reset: rst_n synchronous active low; clears control and the segment count, tables unset.
`timescale 1ns / 1ps
module weighted_stripe_address_mapper (
  input  logic              clk,
  input  logic              rst_n,
  wsam_in_if.sink           in_item,
  wsam_out_if.source        out_item,
  input  logic              cfg_we,
  input  logic [3:0]        cfg_data
);
  import wsam_pkg::*;

  // segment and disk tables
  logic [DW-1:0]      seg_begin_m  [MAX_SEGMENTS];
  logic [DW-1:0]      seg_end_m    [MAX_SEGMENTS];
  logic [DW-1:0]      seg_stripe_m [MAX_SEGMENTS];
  logic [DISK_CW-1:0] seg_dcnt_m   [MAX_SEGMENTS];
  logic [7:0]         dk_weight_m  [DK_DEPTH];
  logic [7:0]         dk_number_m  [DK_DEPTH];

  // registered table reads
  logic [DW-1:0]      rd_begin_r, rd_end_r, rd_stripe_r;
  logic [DISK_CW-1:0] rd_dcnt_r;
  logic [7:0]         rd_w_r, rd_num_r;

  logic [3:0]         seg_count_r;
  state_t             state_r, state_nxt;
  logic [SEG_CW-1:0]  seg_idx_r, seg_idx_nxt;
  logic [DISK_CW-1:0] dsk_idx_r, dsk_idx_nxt;
  logic [DW-1:0]      base_r, base_nxt;      // running prefix sum of slot bytes
  logic [DW-1:0]      off_rel_r, off_rel_nxt;
  logic [DW-1:0]      part_r, part_nxt;
  logic [DW-1:0]      logical_r, logical_nxt;

  // item fields held for the duration of the work
  logic [DW-1:0]      addr_r;
  logic [7:0]         disk_id_r;

  // pending result
  logic               res_status_r, res_status_nxt;
  logic [7:0]         res_disk_r, res_disk_nxt;
  logic [DW-1:0]      res_doff_r, res_doff_nxt;
  logic [DW-1:0]      res_len_r, res_len_nxt;
  logic [DW-1:0]      res_log_r, res_log_nxt;

  // output register
  logic               out_valid_r, out_valid_nxt;
  logic               out_load;
  logic               out_status_r;
  logic [7:0]         out_disk_r;
  logic [DW-1:0]      out_doff_r, out_len_r, out_log_r;

  logic               acc;
  func_t              in_func;
  logic [SEG_CW-1:0]  nseg;
  logic [DW-1:0]      sb;
  logic [DW-1:0]      next_base;
  logic [DK_AW-1:0]   wr_dk_addr, rd_dk_addr;
  logic [3:0]         total_in;

  logic               div_start, div_done;
  logic [DW-1:0]      div_a, div_b, div_quot, div_rem;
  logic               mul_start, mul_done;
  logic [DW-1:0]      mul_a, mul_b, mul_prod;

  wsam_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  wsam_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .op_a  (mul_a),
    .op_b  (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  assign in_item.ready = (state_r == ST_IDLE);
  assign acc           = in_item.valid && in_item.ready;
  assign in_func       = func_t'(in_item.func);

  // counts above the table depth act as the full table
  assign nseg = (int'(seg_count_r) > MAX_SEGMENTS) ? SEG_CW'(MAX_SEGMENTS)
                                                   : SEG_CW'(seg_count_r);

  assign sb        = slot_bytes(rd_w_r);
  assign next_base = base_r + sb;
  assign total_in  = (int'(in_item.disk_total) > MAX_DISKS) ? 4'(MAX_DISKS)
                                                            : in_item.disk_total;

  assign wr_dk_addr = DK_AW'(int'(in_item.seg_slot) * MAX_DISKS + int'(in_item.disk_slot));
  assign rd_dk_addr = DK_AW'(int'(seg_idx_r[SEG_AW-1:0]) * MAX_DISKS
                             + int'(dsk_idx_r[DISK_AW-1:0]));

  // table writes on load items
  always_ff @(posedge clk) begin
    if (acc && in_func == FN_LOAD_SEG && int'(in_item.seg_slot) < MAX_SEGMENTS) begin
      seg_begin_m[SEG_AW'(in_item.seg_slot)]  <= in_item.addr;
      seg_end_m[SEG_AW'(in_item.seg_slot)]    <= in_item.end_addr;
      seg_stripe_m[SEG_AW'(in_item.seg_slot)] <= in_item.stripe_bytes;
      seg_dcnt_m[SEG_AW'(in_item.seg_slot)]   <= DISK_CW'(total_in);
    end
    if (acc && in_func == FN_LOAD_DISK && int'(in_item.seg_slot) < MAX_SEGMENTS
        && int'(in_item.disk_slot) < MAX_DISKS) begin
      dk_weight_m[wr_dk_addr] <= in_item.weight;
      dk_number_m[wr_dk_addr] <= in_item.disk_id;
    end
  end

  // reads follow the scan indexes, data lands in the cycle after
  always_ff @(posedge clk) begin
    rd_begin_r  <= seg_begin_m[seg_idx_r[SEG_AW-1:0]];
    rd_end_r    <= seg_end_m[seg_idx_r[SEG_AW-1:0]];
    rd_stripe_r <= seg_stripe_m[seg_idx_r[SEG_AW-1:0]];
    rd_dcnt_r   <= seg_dcnt_m[seg_idx_r[SEG_AW-1:0]];
    rd_w_r      <= dk_weight_m[rd_dk_addr];
    rd_num_r    <= dk_number_m[rd_dk_addr];
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    seg_idx_nxt    = seg_idx_r;
    dsk_idx_nxt    = dsk_idx_r;
    base_nxt       = base_r;
    off_rel_nxt    = off_rel_r;
    part_nxt       = part_r;
    logical_nxt    = logical_r;
    res_status_nxt = res_status_r;
    res_disk_nxt   = res_disk_r;
    res_doff_nxt   = res_doff_r;
    res_len_nxt    = res_len_r;
    res_log_nxt    = res_log_r;
    out_valid_nxt  = out_valid_r && !out_item.ready;
    out_load       = 1'b0;
    div_start      = 1'b0;
    div_a          = addr_r;
    div_b          = sb;
    mul_start      = 1'b0;
    mul_a          = div_quot;
    mul_b          = sb;

    unique case (state_r)
      ST_IDLE: begin
        if (acc && (in_func == FN_FWD || in_func == FN_REV)) begin
          res_status_nxt = 1'b1;
          res_disk_nxt   = '0;
          res_doff_nxt   = '0;
          res_len_nxt    = '0;
          res_log_nxt    = '0;
          seg_idx_nxt    = '0;
          if (in_func == FN_FWD) begin
            state_nxt = ST_F_SEG;
          end else if (nseg == '0) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_R_SEG;
          end
        end
      end

      // forward: first segment holding the address
      ST_F_SEG: begin
        if (seg_idx_r == nseg) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_F_CHK;
        end
      end
      ST_F_CHK: begin
        if (addr_r >= rd_begin_r && addr_r < rd_end_r) begin
          if (rd_stripe_r == '0) begin
            state_nxt = ST_DONE;
          end else begin
            div_start   = 1'b1;
            div_a       = addr_r - rd_begin_r;
            div_b       = rd_stripe_r;
            dsk_idx_nxt = '0;
            base_nxt    = '0;
            state_nxt   = ST_F_DIV;
          end
        end else begin
          seg_idx_nxt = seg_idx_r + SEG_CW'(1);
          state_nxt   = ST_F_SEG;
        end
      end
      ST_F_DIV: begin
        if (div_done) begin
          state_nxt = ST_F_DRD;
        end
      end
      ST_F_DRD: begin
        if (dsk_idx_r == rd_dcnt_r) begin
          // offset beyond every window: fall back to slot zero
          dsk_idx_nxt = '0;
          state_nxt   = ST_F_PRD;
        end else begin
          state_nxt = ST_F_DCHK;
        end
      end
      ST_F_DCHK: begin
        if (div_rem >= base_r && div_rem < next_base) begin
          mul_start    = 1'b1;
          res_disk_nxt = rd_num_r;
          res_len_nxt  = sb;
          off_rel_nxt  = div_rem - base_r;
          state_nxt    = ST_F_MUL;
        end else begin
          base_nxt    = next_base;
          dsk_idx_nxt = dsk_idx_r + DISK_CW'(1);
          state_nxt   = ST_F_DRD;
        end
      end
      ST_F_PRD: begin
        state_nxt = ST_F_PCHK;
      end
      ST_F_PCHK: begin
        mul_start    = 1'b1;
        res_disk_nxt = rd_num_r;
        res_len_nxt  = sb;
        off_rel_nxt  = div_rem;
        state_nxt    = ST_F_MUL;
      end
      ST_F_MUL: begin
        if (mul_done) begin
          res_doff_nxt   = mul_prod + off_rel_r;
          res_status_nxt = 1'b0;
          state_nxt      = ST_DONE;
        end
      end

      // reverse: per segment, find the disk slot, rebuild, range check
      ST_R_SEG: begin
        if (seg_idx_r == nseg) begin
          res_log_nxt = '1;
          state_nxt   = ST_DONE;
        end else begin
          dsk_idx_nxt = '0;
          base_nxt    = '0;
          state_nxt   = ST_R_HDR;
        end
      end
      ST_R_HDR: begin
        state_nxt = ST_R_DRD;
      end
      ST_R_DRD: begin
        if (dsk_idx_r == rd_dcnt_r) begin
          seg_idx_nxt = seg_idx_r + SEG_CW'(1);
          state_nxt   = ST_R_SEG;
        end else begin
          state_nxt = ST_R_DCHK;
        end
      end
      ST_R_DCHK: begin
        if (rd_num_r == disk_id_r) begin
          if (sb == '0) begin
            seg_idx_nxt = seg_idx_r + SEG_CW'(1);
            state_nxt   = ST_R_SEG;
          end else begin
            div_start = 1'b1;
            state_nxt = ST_R_DIV;
          end
        end else begin
          base_nxt    = next_base;
          dsk_idx_nxt = dsk_idx_r + DISK_CW'(1);
          state_nxt   = ST_R_DRD;
        end
      end
      ST_R_DIV: begin
        if (div_done) begin
          part_nxt  = div_rem + base_r;
          state_nxt = ST_R_SUM;
        end
      end
      ST_R_SUM: begin
        part_nxt  = part_r + rd_begin_r;
        mul_start = 1'b1;
        mul_b     = rd_stripe_r;
        state_nxt = ST_R_MUL;
      end
      ST_R_MUL: begin
        if (mul_done) begin
          logical_nxt = mul_prod + part_r;
          state_nxt   = ST_R_CHK;
        end
      end
      ST_R_CHK: begin
        if (logical_r >= rd_begin_r && logical_r < rd_end_r) begin
          res_status_nxt = 1'b0;
          res_log_nxt    = logical_r;
          state_nxt      = ST_DONE;
        end else begin
          seg_idx_nxt = seg_idx_r + SEG_CW'(1);
          state_nxt   = ST_R_SEG;
        end
      end

      ST_DONE: begin
        // wait for the output register to free up
        if (!out_valid_r || out_item.ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      seg_count_r <= '0;
      seg_idx_r   <= '0;
      dsk_idx_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      seg_idx_r   <= seg_idx_nxt;
      dsk_idx_r   <= dsk_idx_nxt;
      if (cfg_we) begin
        seg_count_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    base_r       <= base_nxt;
    off_rel_r    <= off_rel_nxt;
    part_r       <= part_nxt;
    logical_r    <= logical_nxt;
    res_status_r <= res_status_nxt;
    res_disk_r   <= res_disk_nxt;
    res_doff_r   <= res_doff_nxt;
    res_len_r    <= res_len_nxt;
    res_log_r    <= res_log_nxt;
    if (acc) begin
      addr_r    <= in_item.addr;
      disk_id_r <= in_item.disk_id;
    end
    if (out_load) begin
      out_status_r <= res_status_r;
      out_disk_r   <= res_disk_r;
      out_doff_r   <= res_doff_r;
      out_len_r    <= res_len_r;
      out_log_r    <= res_log_r;
    end
  end

  assign out_item.valid           = out_valid_r;
  assign out_item.status          = out_status_r;
  assign out_item.disk_out        = out_disk_r;
  assign out_item.disk_offset_out = out_doff_r;
  assign out_item.chunk_length    = out_len_r;
  assign out_item.logical_out     = out_log_r;
endmodule
